// ===== design/pirb_pkg.sv =====
// ----------------------------------------------------------------------------
// pirb_pkg
// Shared constants, the quarter-wave sine table and types for the
// point-in-rotated-box test.
// ----------------------------------------------------------------------------
package pirb_pkg;

  localparam int COORD_BITS_DEF = 24;
  localparam int FRAC_BITS_DEF  = 8;
  localparam int ANGLE_BITS_DEF = 16;

  localparam int              MARGIN_W     = 8;
  localparam logic [MARGIN_W-1:0] MARGIN_RESET = 8'd3;

  // Q1.15 sine/cosine, range -32768..32768
  localparam int TRIG_W   = 17;
  localparam int ROM_W    = 16;
  localparam int ROM_IDX_W = 7;
  localparam int ROM_LAST = 64;

  localparam logic [ROM_W-1:0] SIN_ROM [ROM_LAST+1] = '{
    16'd0,     16'd804,   16'd1608,  16'd2411,  16'd3212,  16'd4011,  16'd4808,  16'd5602,
    16'd6393,  16'd7180,  16'd7962,  16'd8740,  16'd9512,  16'd10279, 16'd11039, 16'd11793,
    16'd12540, 16'd13279, 16'd14010, 16'd14733, 16'd15447, 16'd16151, 16'd16846, 16'd17531,
    16'd18205, 16'd18868, 16'd19520, 16'd20160, 16'd20788, 16'd21403, 16'd22006, 16'd22595,
    16'd23170, 16'd23732, 16'd24279, 16'd24812, 16'd25330, 16'd25833, 16'd26320, 16'd26791,
    16'd27246, 16'd27684, 16'd28106, 16'd28511, 16'd28899, 16'd29269, 16'd29622, 16'd29957,
    16'd30274, 16'd30572, 16'd30853, 16'd31114, 16'd31357, 16'd31581, 16'd31786, 16'd31972,
    16'd32138, 16'd32286, 16'd32413, 16'd32522, 16'd32610, 16'd32679, 16'd32729, 16'd32758,
    16'd32768
  };

  typedef struct packed {
    logic signed [TRIG_W-1:0] c;
    logic signed [TRIG_W-1:0] s;
  } trig_t;

  // entries past the last one read as full scale
  function automatic logic [ROM_W-1:0] sin_rom_at(input logic [ROM_IDX_W-1:0] idx);
    if (idx >= ROM_IDX_W'(ROM_LAST)) begin
      return SIN_ROM[ROM_LAST];
    end
    return SIN_ROM[idx];
  endfunction

endpackage

// ===== design/pirb_trig.sv =====
// ----------------------------------------------------------------------------
// pirb_trig
// Two-stage sine/cosine of the heading: quadrant fold and table lookup,
// then linear interpolation and sign.
// ----------------------------------------------------------------------------
module pirb_trig #(
  parameter int ANGLE_BITS = pirb_pkg::ANGLE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic [ANGLE_BITS-1:0] heading_i,
  output pirb_pkg::trig_t       trig_o
);
  import pirb_pkg::*;

  localparam int QUAD_W   = ANGLE_BITS - 2;
  localparam int INTERP_W = ANGLE_BITS - 8;
  localparam int FR_W     = (INTERP_W > 0) ? INTERP_W : 1;
  localparam int PROD_W   = ROM_W + FR_W;

  typedef struct packed {
    logic             neg;
    logic [ROM_W-1:0] base;
    logic [ROM_W-1:0] diff;
    logic [FR_W-1:0]  fr;
  } quarter_t;

  function automatic quarter_t split_phase(input logic [ANGLE_BITS-1:0] phase);
    logic [QUAD_W:0]        r;
    logic [ROM_IDX_W-1:0]   idx;
    quarter_t               o;
    r = phase[ANGLE_BITS-2] ?
        ({1'b1, {QUAD_W{1'b0}}} - {1'b0, phase[QUAD_W-1:0]}) :
        {1'b0, phase[QUAD_W-1:0]};
    idx    = ROM_IDX_W'(r >> INTERP_W);
    o.neg  = phase[ANGLE_BITS-1];
    o.base = sin_rom_at(idx);
    o.diff = sin_rom_at(idx + ROM_IDX_W'(1)) - o.base;
    o.fr   = (INTERP_W > 0) ? r[FR_W-1:0] : '0;
    return o;
  endfunction

  function automatic logic signed [TRIG_W-1:0] interp(input quarter_t q);
    logic [PROD_W-1:0]   prod;
    logic [PROD_W:0]     v;
    logic [PROD_W:0]     rnd;
    logic [ROM_W-1:0]    mag;
    prod = q.diff * q.fr;
    v    = {prod, 1'b0} >> INTERP_W;
    rnd  = (v + (PROD_W+1)'(1)) >> 1;
    mag  = q.base + rnd[ROM_W-1:0];
    return q.neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

  logic [ANGLE_BITS-1:0] cos_phase;
  quarter_t              sin_q, sin_d, cos_q, cos_d;
  trig_t                 trig_q, trig_d;

  assign cos_phase = heading_i + {2'b01, {QUAD_W{1'b0}}};

  always_comb begin
    sin_d    = split_phase(heading_i);
    cos_d    = split_phase(cos_phase);
    trig_d.s = interp(sin_q);
    trig_d.c = interp(cos_q);
  end

  always_ff @(posedge clk_i) begin
    sin_q  <= sin_d;
    cos_q  <= cos_d;
    trig_q <= trig_d;
  end

  assign trig_o = trig_q;

endmodule

// ===== design/pirb_rotate.sv =====
// ----------------------------------------------------------------------------
// pirb_rotate
// Two-stage rotation of the planar offset by minus the heading: four
// products, then sum and difference.
// ----------------------------------------------------------------------------
module pirb_rotate #(
  parameter int COORD_BITS = pirb_pkg::COORD_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic signed [COORD_BITS:0]        sx_i,
  input  logic signed [COORD_BITS:0]        sy_i,
  input  pirb_pkg::trig_t                   trig_i,
  output logic signed [COORD_BITS+pirb_pkg::TRIG_W+1:0] lx_o,
  output logic signed [COORD_BITS+pirb_pkg::TRIG_W+1:0] ly_o
);
  import pirb_pkg::*;

  localparam int PROD_W = COORD_BITS + 1 + TRIG_W;
  localparam int SUM_W  = PROD_W + 1;

  logic signed [PROD_W-1:0] xc_q, xc_d, ys_q, ys_d, yc_q, yc_d, xs_q, xs_d;
  logic signed [SUM_W-1:0]  lx_q, lx_d, ly_q, ly_d;

  always_comb begin
    xc_d = sx_i * trig_i.c;
    ys_d = sy_i * trig_i.s;
    yc_d = sy_i * trig_i.c;
    xs_d = sx_i * trig_i.s;
    lx_d = SUM_W'(xc_q) + SUM_W'(ys_q);
    ly_d = SUM_W'(yc_q) - SUM_W'(xs_q);
  end

  always_ff @(posedge clk_i) begin
    xc_q <= xc_d;
    ys_q <= ys_d;
    yc_q <= yc_d;
    xs_q <= xs_d;
    lx_q <= lx_d;
    ly_q <= ly_d;
  end

  assign lx_o = lx_q;
  assign ly_o = ly_q;

endmodule

// ===== design/point_in_rotated_box_test.sv =====
// ----------------------------------------------------------------------------
// point_in_rotated_box_test
// Tests whether a point lies inside a box with a center, full sizes and a
// yaw heading, one point/box pair per clock.
//
// Usage:
//   Command channel: a transaction is taken at a rising edge with start high
//   and busy low. busy is always low, so a new pair can be issued every cycle.
//   Result channel: done_o is high for exactly one cycle with inside_res_o
//   valid; results come out in issue order. The receiver cannot stall.
//   Pipeline: done_o follows the issuing edge through the input register,
//   offset/lookup, interpolation, products, sums and compare. Throughput is one
//   pair per cycle, set by the fully pipelined datapath.
//   Config: margin is written through cfg_valid_i/cfg_ready_o/cfg_margin_i;
//   cfg_ready_o is always high. Write only while no transaction is in flight.
//   Reset: clears the pipeline valid bits and sets margin to 3; no result is
//   produced for a transaction still in flight when reset is asserted.
// ----------------------------------------------------------------------------
module point_in_rotated_box_test #(
  parameter int COORD_BITS = pirb_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = pirb_pkg::FRAC_BITS_DEF,
  parameter int ANGLE_BITS = pirb_pkg::ANGLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_BITS-1:0]  point_x_i,
  input  logic signed [COORD_BITS-1:0]  point_y_i,
  input  logic signed [COORD_BITS-1:0]  point_z_i,
  input  logic signed [COORD_BITS-1:0]  center_x_i,
  input  logic signed [COORD_BITS-1:0]  center_y_i,
  input  logic signed [COORD_BITS-1:0]  center_z_i,
  input  logic        [COORD_BITS-2:0]  size_x_i,
  input  logic        [COORD_BITS-2:0]  size_y_i,
  input  logic        [COORD_BITS-2:0]  size_z_i,
  input  logic        [ANGLE_BITS-1:0]  heading_i,
  output logic                          done_o,
  output logic                          inside_res_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pirb_pkg::MARGIN_W-1:0] cfg_margin_i
);
  import pirb_pkg::*;

  localparam int SX_W  = COORD_BITS + 1;
  localparam int SUM_W = COORD_BITS + TRIG_W + 2;
  localparam int CMP_W = (SUM_W > FRAC_BITS + 17) ? SUM_W : FRAC_BITS + 17;
  localparam int TH_W  = CMP_W - 1;
  localparam int SZ_W  = COORD_BITS - 1;

  logic                  accept;
  logic [MARGIN_W-1:0]   margin_q;

  logic valid_a_q, valid_b_q, valid_c_q, valid_d_q, valid_e_q, done_q;

  // stage A: input register
  logic signed [COORD_BITS-1:0] px_a_q, py_a_q, pz_a_q, cx_a_q, cy_a_q, cz_a_q;
  logic        [SZ_W-1:0]       size_x_a_q, size_y_a_q, size_z_a_q;
  logic        [ANGLE_BITS-1:0] heading_a_q;

  // stage B: offsets and height check
  logic signed [SX_W-1:0]   sx_b_d, sy_b_d, sx_b_q, sy_b_q;
  logic signed [SX_W:0]     dz2_b, sz_b;
  logic                     zok_b_d, zok_b_q;
  logic        [SZ_W-1:0]   size_x_b_q, size_y_b_q;

  // stage C
  logic signed [SX_W-1:0]   sx_c_q, sy_c_q;
  logic                     zok_c_q;
  logic        [SZ_W-1:0]   size_x_c_q, size_y_c_q;
  trig_t                    trig_c;

  // stage D, E: planar thresholds
  logic [TH_W-1:0]          mterm, thr_x_d_d, thr_y_d_d;
  logic [TH_W-1:0]          thr_x_d_q, thr_y_d_q, thr_x_e_q, thr_y_e_q;
  logic                     zok_d_q, zok_e_q;
  logic signed [SUM_W-1:0]  lx_e, ly_e;

  // stage F: compare
  logic signed [CMP_W-1:0]  lx_f, ly_f, tx_f, ty_f;
  logic                     inside_d, inside_q;

  assign accept      = start && !busy;
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q <= MARGIN_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      margin_q <= cfg_margin_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
      valid_c_q <= 1'b0;
      valid_d_q <= 1'b0;
      valid_e_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      valid_a_q <= accept;
      valid_b_q <= valid_a_q;
      valid_c_q <= valid_b_q;
      valid_d_q <= valid_c_q;
      valid_e_q <= valid_d_q;
      done_q    <= valid_e_q;
    end
  end

  always_comb begin
    sx_b_d  = SX_W'(px_a_q) - SX_W'(cx_a_q);
    sy_b_d  = SX_W'(py_a_q) - SX_W'(cy_a_q);
    dz2_b   = {SX_W'(pz_a_q) - SX_W'(cz_a_q), 1'b0};
    sz_b    = $signed({3'b000, size_z_a_q});
    zok_b_d = (dz2_b <= sz_b) && (dz2_b >= -sz_b);

    mterm     = TH_W'(margin_q) << (FRAC_BITS + 7);
    thr_x_d_d = (TH_W'(size_x_c_q) << 14) + mterm;
    thr_y_d_d = (TH_W'(size_y_c_q) << 14) + mterm;

    lx_f = CMP_W'(lx_e);
    ly_f = CMP_W'(ly_e);
    tx_f = $signed({1'b0, thr_x_e_q});
    ty_f = $signed({1'b0, thr_y_e_q});
    inside_d = zok_e_q && (lx_f < tx_f) && (lx_f > -tx_f) &&
               (ly_f < ty_f) && (ly_f > -ty_f);
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_a_q      <= point_x_i;
      py_a_q      <= point_y_i;
      pz_a_q      <= point_z_i;
      cx_a_q      <= center_x_i;
      cy_a_q      <= center_y_i;
      cz_a_q      <= center_z_i;
      size_x_a_q  <= size_x_i;
      size_y_a_q  <= size_y_i;
      size_z_a_q  <= size_z_i;
      heading_a_q <= heading_i;
    end
    sx_b_q     <= sx_b_d;
    sy_b_q     <= sy_b_d;
    zok_b_q    <= zok_b_d;
    size_x_b_q <= size_x_a_q;
    size_y_b_q <= size_y_a_q;
    sx_c_q     <= sx_b_q;
    sy_c_q     <= sy_b_q;
    zok_c_q    <= zok_b_q;
    size_x_c_q <= size_x_b_q;
    size_y_c_q <= size_y_b_q;
    thr_x_d_q  <= thr_x_d_d;
    thr_y_d_q  <= thr_y_d_d;
    zok_d_q    <= zok_c_q;
    thr_x_e_q  <= thr_x_d_q;
    thr_y_e_q  <= thr_y_d_q;
    zok_e_q    <= zok_d_q;
    inside_q   <= inside_d;
  end

  pirb_trig #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_trig (
    .clk_i    (clk_i),
    .heading_i(heading_a_q),
    .trig_o   (trig_c)
  );

  pirb_rotate #(
    .COORD_BITS(COORD_BITS)
  ) u_rotate (
    .clk_i (clk_i),
    .sx_i  (sx_c_q),
    .sy_i  (sy_c_q),
    .trig_i(trig_c),
    .lx_o  (lx_e),
    .ly_o  (ly_e)
  );

  assign done_o       = done_q;
  assign inside_res_o = inside_q;

`ifndef SYNTHESIS
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##6 done_o)
    else $error("accepted transaction did not complete in six cycles");

  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 6))
    else $error("result without a matching transaction");

  a_height_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_b_q && !zok_b_q) |-> ##4 (done_o && !inside_res_o))
    else $error("point outside height range reported inside");

  a_margin_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cfg_valid_i && cfg_ready_o) |=> $stable(margin_q))
    else $error("margin changed without a config write");
`endif

endmodule
